>>> rtl/tcp_ct_pkg.sv
`timescale 1ns / 1ps
package tcp_ct_pkg;
	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int IDX_W = 10;

	localparam logic [2:0] REQ_LOOKUP   = 3'd0;
	localparam logic [2:0] REQ_ALLOCATE = 3'd1;
	localparam logic [2:0] REQ_BIND     = 3'd2;
	localparam logic [2:0] REQ_LISTEN   = 3'd3;
	localparam logic [2:0] REQ_SET      = 3'd4;
	localparam logic [2:0] REQ_RELEASE  = 3'd5;

	localparam logic [2:0] RES_OK          = 3'd0;
	localparam logic [2:0] RES_NOT_FOUND   = 3'd1;
	localparam logic [2:0] RES_BAD_PARAM   = 3'd2;
	localparam logic [2:0] RES_PORT_USED   = 3'd3;
	localparam logic [2:0] RES_WRONG_STATE = 3'd4;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_EXACT  = 2'd1;
	localparam logic [1:0] KIND_LISTEN = 2'd2;

	localparam logic [3:0] ST_FREE   = 4'd0;
	localparam logic [3:0] ST_CLOSED = 4'd1;
	localparam logic [3:0] ST_LISTEN = 4'd2;
	localparam logic [3:0] ST_MAX    = 4'd9;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [5:0]  slot;
		logic [31:0] peer_addr;
		logic [15:0] peer_port;
		logic [15:0] own_port;
		logic [3:0]  new_conn_state;
	} req_t;

	typedef struct packed {
		logic             exact_hit;
		logic [IDX_W-1:0] exact_idx;
		logic [3:0]       exact_state;
		logic             listen_hit;
		logic [IDX_W-1:0] listen_idx;
		logic             port_used;
		logic             free_hit;
		logic [IDX_W-1:0] free_idx;
		logic [3:0]       slot_state;
		logic             slot_port_zero;
	} acc_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic             st_en;
		logic [3:0]       st;
		logic             port_en;
		logic [15:0]      port;
		logic             peer_en;
		logic [31:0]      addr;
		logic [15:0]      rport;
	} wr_t;
endpackage

>>> rtl/tcp_ct_ifs.sv
`timescale 1ns / 1ps
interface tcp_ct_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [5:0]  slot;
	logic [31:0] peer_addr;
	logic [15:0] peer_port;
	logic [15:0] own_port;
	logic [3:0]  new_conn_state;
	modport source (output valid, req_type, slot, peer_addr, peer_port, own_port,
		new_conn_state, input ready);
	modport sink (input valid, req_type, slot, peer_addr, peer_port, own_port,
		new_conn_state, output ready);
endinterface

interface tcp_ct_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [5:0] found_slot;
	logic [1:0] match_kind;
	logic [3:0] found_state;
	modport source (output valid, status, found_slot, match_kind, found_state,
		input ready);
	modport sink (input valid, status, found_slot, match_kind, found_state,
		output ready);
endinterface

>>> rtl/tcp_ct_cell.sv
`timescale 1ns / 1ps
module tcp_ct_cell import tcp_ct_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic tok_in,
	input  acc_t acc_in,
	input  wr_t  wr,
	output logic tok_out,
	output acc_t acc_out
);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [3:0]  st_q;
	logic [15:0] lp_q;
	logic [31:0] ra_q;
	logic [15:0] rp_q;
	logic        tok_q;
	acc_t        acc_q;
	acc_t        acc_nx;
	logic        live;
	logic        lpm;
	logic        hit_me;

	assign hit_me = wr.en && (wr.idx == MY_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_FREE;
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (hit_me && wr.st_en) begin
				st_q <= wr.st;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_me && wr.port_en) begin
			lp_q <= wr.port;
		end
		if (hit_me && wr.peer_en) begin
			ra_q <= wr.addr;
			rp_q <= wr.rport;
		end
		if (tok_in) begin
			acc_q <= acc_nx;
		end
	end

	assign live = (st_q != ST_FREE);
	assign lpm  = (lp_q == req.own_port);

	always_comb begin
		acc_nx = acc_in;
		if (!acc_in.exact_hit && live && lpm) begin
			if (ra_q == req.peer_addr && rp_q == req.peer_port) begin
				acc_nx.exact_hit   = 1'b1;
				acc_nx.exact_idx   = MY_IDX;
				acc_nx.exact_state = st_q;
			end else if (st_q == ST_LISTEN) begin
				acc_nx.listen_hit = 1'b1;
				acc_nx.listen_idx = MY_IDX;
			end
		end
		if (live && lpm && ({4'b0, req.slot} != MY_IDX)) begin
			acc_nx.port_used = 1'b1;
		end
		if (!acc_in.free_hit && !live) begin
			acc_nx.free_hit = 1'b1;
			acc_nx.free_idx = MY_IDX;
		end
		if ({4'b0, req.slot} == MY_IDX) begin
			acc_nx.slot_state     = st_q;
			acc_nx.slot_port_zero = (lp_q == 16'd0);
		end
	end

	assign tok_out = tok_q;
	assign acc_out = acc_q;
endmodule

>>> rtl/tcp_connection_table.sv
`timescale 1ns / 1ps
// Connection table built as a row of TABLE_ENTRIES cells, one entry per cell.
// A request is taken when the block is idle and its result word has been taken;
// a scan token then walks the row one cell per cycle, gathering the exact match,
// listen fallback, port use and lowest free entry, and any update is written
// when it leaves the last cell, where the result word is also registered. Port and address
// fields of an entry hold no value until written.
module tcp_connection_table import tcp_ct_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tcp_ct_req_if.sink   req,
	tcp_ct_rsp_if.source rsp
);
	logic                  busy_q;
	logic                  start_q;
	req_t                  req_q;
	logic                  out_valid_q;
	logic [2:0]            status_q;
	logic [5:0]            slot_q;
	logic [1:0]            kind_q;
	logic [3:0]            state_q;
	logic [TABLE_ENTRIES-1:0] tok;
	acc_t                  acc [TABLE_ENTRIES];
	acc_t                  fin;
	logic                  finish;
	logic                  accept;
	logic                  slot_bad;
	wr_t                   wr;
	logic [2:0]            r_status;
	logic [5:0]            r_slot;
	logic [1:0]            r_kind;
	logic [3:0]            r_state;

	assign req.ready = !busy_q && !out_valid_q;
	assign accept    = req.valid && req.ready;
	assign finish    = tok[TABLE_ENTRIES-1];
	assign fin       = acc[TABLE_ENTRIES-1];
	assign slot_bad  = (IDX_W+1)'(req_q.slot) >= (IDX_W+1)'(TABLE_ENTRIES);

	genvar g;
	generate
		for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
			if (g == 0) begin : g_head
				tcp_ct_cell #(.INDEX(g)) u_cell (
					.clk(clk), .arst_n(arst_n), .req(req_q), .tok_in(start_q),
					.acc_in('0), .wr(wr), .tok_out(tok[g]), .acc_out(acc[g])
				);
			end else begin : g_body
				tcp_ct_cell #(.INDEX(g)) u_cell (
					.clk(clk), .arst_n(arst_n), .req(req_q), .tok_in(tok[g-1]),
					.acc_in(acc[g-1]), .wr(wr), .tok_out(tok[g]), .acc_out(acc[g])
				);
			end
		end
	endgenerate

	always_comb begin
		wr       = '0;
		wr.idx   = IDX_W'(req_q.slot);
		r_status = RES_OK;
		r_slot   = req_q.slot;
		r_kind   = KIND_NONE;
		r_state  = fin.slot_state;
		if (req_q.req_type == REQ_LOOKUP) begin
			if (fin.exact_hit) begin
				r_slot  = fin.exact_idx[5:0];
				r_kind  = KIND_EXACT;
				r_state = fin.exact_state;
			end else if (fin.listen_hit) begin
				r_slot  = fin.listen_idx[5:0];
				r_kind  = KIND_LISTEN;
				r_state = ST_LISTEN;
			end else begin
				r_status = RES_NOT_FOUND;
				r_slot   = 6'd0;
				r_state  = ST_FREE;
			end
		end else if (req_q.req_type == REQ_ALLOCATE) begin
			if (fin.free_hit) begin
				r_slot     = fin.free_idx[5:0];
				r_state    = ST_CLOSED;
				wr.en      = finish;
				wr.idx     = fin.free_idx;
				wr.st_en   = 1'b1;
				wr.st      = ST_CLOSED;
				wr.port_en = 1'b1;
				wr.peer_en = 1'b1;
			end else begin
				r_status = RES_NOT_FOUND;
				r_slot   = 6'd0;
				r_state  = ST_FREE;
			end
		end else if (req_q.req_type > REQ_RELEASE) begin
			r_status = RES_BAD_PARAM;
			r_slot   = 6'd0;
			r_state  = ST_FREE;
		end else if (slot_bad) begin
			r_status = RES_BAD_PARAM;
			r_state  = ST_FREE;
		end else begin
			unique case (req_q.req_type)
				REQ_BIND: begin
					if (req_q.own_port == 16'd0) begin
						r_status = RES_BAD_PARAM;
					end else if (fin.port_used) begin
						r_status = RES_PORT_USED;
					end else begin
						wr.en      = finish;
						wr.port_en = 1'b1;
						wr.port    = req_q.own_port;
					end
				end
				REQ_LISTEN: begin
					if (fin.slot_state != ST_CLOSED) begin
						r_status = RES_WRONG_STATE;
					end else if (fin.slot_port_zero) begin
						r_status = RES_BAD_PARAM;
					end else begin
						r_state  = ST_LISTEN;
						wr.en    = finish;
						wr.st_en = 1'b1;
						wr.st    = ST_LISTEN;
					end
				end
				REQ_SET: begin
					if (req_q.new_conn_state > ST_MAX) begin
						r_status = RES_BAD_PARAM;
					end else begin
						r_state    = req_q.new_conn_state;
						wr.en      = finish;
						wr.st_en   = 1'b1;
						wr.st      = req_q.new_conn_state;
						wr.port_en = 1'b1;
						wr.port    = req_q.own_port;
						wr.peer_en = 1'b1;
						wr.addr    = req_q.peer_addr;
						wr.rport   = req_q.peer_port;
					end
				end
				default: begin
					r_state  = ST_FREE;
					wr.en    = finish;
					wr.st_en = 1'b1;
					wr.st    = ST_FREE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.req_type       <= req.req_type;
			req_q.slot           <= req.slot;
			req_q.peer_addr      <= req.peer_addr;
			req_q.peer_port      <= req.peer_port;
			req_q.own_port       <= req.own_port;
			req_q.new_conn_state <= req.new_conn_state;
		end
		if (finish) begin
			status_q <= r_status;
			slot_q   <= r_slot;
			kind_q   <= r_kind;
			state_q  <= r_state;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.found_slot  = slot_q;
	assign rsp.match_kind  = kind_q;
	assign rsp.found_state = state_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok, start_q}))
		else $error("more than one scan token in the cell row");

	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> rsp.valid)
		else $error("scan finished without a result word");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> busy_q && !out_valid_q)
		else $error("scan finished while idle or with a result pending");

	a_kind_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		finish && req_q.req_type != REQ_LOOKUP |-> r_kind == KIND_NONE)
		else $error("match kind set on a non-lookup request");
endmodule

>>> bench/tcp_connection_table_test.sv
`timescale 1ns / 1ps
module tcp_connection_table_test;
	import tcp_ct_pkg::*;

	localparam int NUM_ENTRIES = 64;
	localparam int RANDOM_ITEMS = 500;
	localparam int DRAIN_CYCLES = 2 * NUM_ENTRIES + 10;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] found_slot;
		logic [1:0] match_kind;
		logic [3:0] found_state;
	} answer_t;

	typedef struct packed {
		req_t    word;
		logic    known;
		answer_t answer;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tcp_ct_req_if req ();
	tcp_ct_rsp_if rsp ();

	tcp_connection_table #(.TABLE_ENTRIES(NUM_ENTRIES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always #5 clk = ~clk;

	logic [3:0]  conn_state [NUM_ENTRIES];
	logic [15:0] conn_lport [NUM_ENTRIES];
	logic [31:0] conn_raddr [NUM_ENTRIES];
	logic [15:0] conn_rport [NUM_ENTRIES];

	answer_t pending_answers[$];
	answer_t typed_answers[$];
	logic    typed_known[$];
	int      errors = 0;
	int      tx_idle = 0;
	int      rx_idle = 0;

	function automatic answer_t serve_request(req_t r);
		answer_t a;
		logic    have_listen;
		int      listen_at;
		a = '0;
		have_listen = 1'b0;
		listen_at = 0;
		case (r.req_type)
			REQ_LOOKUP: begin
				a.status = RES_NOT_FOUND;
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					if (conn_state[i] != ST_FREE && conn_lport[i] == r.own_port) begin
						if (conn_raddr[i] == r.peer_addr && conn_rport[i] == r.peer_port) begin
							a.status = RES_OK;
							a.found_slot = 6'(i);
							a.match_kind = KIND_EXACT;
							a.found_state = conn_state[i];
							return a;
						end
						if (conn_state[i] == ST_LISTEN) begin
							have_listen = 1'b1;
							listen_at = i;
						end
					end
				end
				if (have_listen) begin
					a.status = RES_OK;
					a.found_slot = 6'(listen_at);
					a.match_kind = KIND_LISTEN;
					a.found_state = conn_state[listen_at];
				end
			end
			REQ_ALLOCATE: begin
				a.status = RES_NOT_FOUND;
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					if (conn_state[i] == ST_FREE) begin
						conn_state[i] = ST_CLOSED;
						conn_lport[i] = '0;
						conn_raddr[i] = '0;
						conn_rport[i] = '0;
						a.status = RES_OK;
						a.found_slot = 6'(i);
						a.found_state = ST_CLOSED;
						return a;
					end
				end
			end
			REQ_BIND: begin
				a.status = RES_OK;
				if (r.own_port == 16'd0) begin
					a.status = RES_BAD_PARAM;
				end else begin
					for (int i = 0; i < NUM_ENTRIES; i++)
						if (i != r.slot && conn_state[i] != ST_FREE && conn_lport[i] == r.own_port)
							a.status = RES_PORT_USED;
					if (a.status == RES_OK)
						conn_lport[r.slot] = r.own_port;
				end
				a.found_slot = r.slot;
				a.found_state = conn_state[r.slot];
			end
			REQ_LISTEN: begin
				if (conn_state[r.slot] != ST_CLOSED) begin
					a.status = RES_WRONG_STATE;
				end else if (conn_lport[r.slot] == 16'd0) begin
					a.status = RES_BAD_PARAM;
				end else begin
					conn_state[r.slot] = ST_LISTEN;
					a.status = RES_OK;
				end
				a.found_slot = r.slot;
				a.found_state = conn_state[r.slot];
			end
			REQ_SET: begin
				a.status = RES_BAD_PARAM;
				if (r.new_conn_state <= ST_MAX) begin
					conn_state[r.slot] = r.new_conn_state;
					conn_lport[r.slot] = r.own_port;
					conn_raddr[r.slot] = r.peer_addr;
					conn_rport[r.slot] = r.peer_port;
					a.status = RES_OK;
				end
				a.found_slot = r.slot;
				a.found_state = conn_state[r.slot];
			end
			REQ_RELEASE: begin
				conn_state[r.slot] = ST_FREE;
				a.status = RES_OK;
				a.found_slot = r.slot;
				a.found_state = ST_FREE;
			end
			default: a.status = RES_BAD_PARAM;
		endcase
		return a;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// word accepted on the request side: predict; result word taken: check it against the prediction and any typed answer
	always @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_t    w;
			answer_t a;
			w = '{req.req_type, req.slot, req.peer_addr, req.peer_port, req.own_port,
				req.new_conn_state};
			a = serve_request(w);
			pending_answers.push_back(a);
		end
		if (rsp.valid && rsp.ready) begin
			answer_t want;
			logic    known;
			answer_t typed;
			if (pending_answers.size() == 0) begin
				$display("mismatch at %0t: result word with nothing pending", $realtime);
				errors++;
			end else begin
				want = pending_answers.pop_front();
				known = typed_known.pop_front();
				typed = typed_answers.pop_front();
				if (known && typed != want)
					report("typed row vs predictor", 32'(typed), 32'(want));
				if (rsp.status !== want.status)
					report("status", 32'(rsp.status), 32'(want.status));
				if (rsp.found_slot !== want.found_slot)
					report("found_slot", 32'(rsp.found_slot), 32'(want.found_slot));
				if (rsp.match_kind !== want.match_kind)
					report("match_kind", 32'(rsp.match_kind), 32'(want.match_kind));
				if (rsp.found_state !== want.found_state)
					report("found_state", 32'(rsp.found_state), 32'(want.found_state));
			end
		end
	end

	always @(negedge clk)
		rsp.ready <= ($urandom_range(99) >= rx_idle);

	task automatic send_word(req_t w, logic known, answer_t a);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		typed_known.push_back(known);
		typed_answers.push_back(a);
		req.req_type <= w.req_type;
		req.slot <= w.slot;
		req.peer_addr <= w.peer_addr;
		req.peer_port <= w.peer_port;
		req.own_port <= w.own_port;
		req.new_conn_state <= w.new_conn_state;
		req.valid <= 1'b1;
		do @(posedge clk); while (!req.ready);
	endtask

	function automatic logic [15:0] pick_port();
		case ($urandom_range(5))
			0: return 16'd1;
			1: return 16'd2;
			2: return 16'd3;
			3: return 16'hffff;
			4: return 16'd0;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_addr();
		case ($urandom_range(3))
			0: return 32'd0;
			1: return 32'hffffffff;
			2: return 32'h0a000001;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t random_word();
		req_t w;
		int   roll;
		roll = $urandom_range(99);
		if (roll < 25) w.req_type = REQ_LOOKUP;
		else if (roll < 50) w.req_type = REQ_ALLOCATE;
		else if (roll < 62) w.req_type = REQ_BIND;
		else if (roll < 72) w.req_type = REQ_LISTEN;
		else if (roll < 85) w.req_type = REQ_SET;
		else if (roll < 96) w.req_type = REQ_RELEASE;
		else w.req_type = 3'($urandom_range(7, 6));
		w.slot = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(15));
		w.peer_addr = pick_addr();
		w.peer_port = pick_port();
		w.own_port = pick_port();
		w.new_conn_state = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 10)) :
			4'($urandom_range(9));
		return w;
	endfunction

	row_t directed [21] = '{
		'{'{REQ_LOOKUP, 6'd0, 32'd0, 16'd0, 16'd80, 4'd0}, 1'b1,
			'{RES_NOT_FOUND, 6'd0, KIND_NONE, ST_FREE}},
		'{'{REQ_ALLOCATE, 6'd0, 32'd0, 16'd0, 16'd0, 4'd0}, 1'b1,
			'{RES_OK, 6'd0, KIND_NONE, ST_CLOSED}},
		'{'{REQ_BIND, 6'd0, 32'd0, 16'd0, 16'd0, 4'd0}, 1'b1,
			'{RES_BAD_PARAM, 6'd0, KIND_NONE, ST_CLOSED}},
		'{'{REQ_BIND, 6'd0, 32'd0, 16'd0, 16'hffff, 4'd0}, 1'b1,
			'{RES_OK, 6'd0, KIND_NONE, ST_CLOSED}},
		'{'{REQ_LISTEN, 6'd0, 32'd0, 16'd0, 16'd0, 4'd0}, 1'b1,
			'{RES_OK, 6'd0, KIND_NONE, ST_LISTEN}},
		'{'{REQ_LISTEN, 6'd0, 32'd0, 16'd0, 16'd0, 4'd0}, 1'b1,
			'{RES_WRONG_STATE, 6'd0, KIND_NONE, ST_LISTEN}},
		'{'{REQ_ALLOCATE, 6'd0, 32'd0, 16'd0, 16'd0, 4'd0}, 1'b1,
			'{RES_OK, 6'd1, KIND_NONE, ST_CLOSED}},
		'{'{REQ_LISTEN, 6'd1, 32'd0, 16'd0, 16'd0, 4'd0}, 1'b1,
			'{RES_BAD_PARAM, 6'd1, KIND_NONE, ST_CLOSED}},
		'{'{REQ_BIND, 6'd1, 32'd0, 16'd0, 16'hffff, 4'd0}, 1'b1,
			'{RES_PORT_USED, 6'd1, KIND_NONE, ST_CLOSED}},
		'{'{REQ_SET, 6'd63, 32'hffffffff, 16'hffff, 16'hffff, 4'd9}, 1'b1,
			'{RES_OK, 6'd63, KIND_NONE, 4'd9}},
		'{'{REQ_SET, 6'd2, 32'd0, 16'd0, 16'd5, 4'd10}, 1'b1,
			'{RES_BAD_PARAM, 6'd2, KIND_NONE, ST_FREE}},
		'{'{REQ_SET, 6'd2, 32'd0, 16'd0, 16'd5, 4'd15}, 1'b1,
			'{RES_BAD_PARAM, 6'd2, KIND_NONE, ST_FREE}},
		'{'{REQ_LOOKUP, 6'd0, 32'hffffffff, 16'hffff, 16'hffff, 4'd0}, 1'b1,
			'{RES_OK, 6'd63, KIND_EXACT, 4'd9}},
		'{'{REQ_LOOKUP, 6'd0, 32'd1, 16'hffff, 16'hffff, 4'd0}, 1'b1,
			'{RES_OK, 6'd0, KIND_LISTEN, ST_LISTEN}},
		'{'{REQ_RELEASE, 6'd63, 32'd0, 16'd0, 16'd0, 4'd0}, 1'b1,
			'{RES_OK, 6'd63, KIND_NONE, ST_FREE}},
		'{'{REQ_RELEASE, 6'd63, 32'd0, 16'd0, 16'd0, 4'd0}, 1'b1,
			'{RES_OK, 6'd63, KIND_NONE, ST_FREE}},
		'{'{3'd6, 6'd0, 32'd0, 16'd0, 16'd0, 4'd0}, 1'b1,
			'{RES_BAD_PARAM, 6'd0, KIND_NONE, ST_FREE}},
		'{'{3'd7, 6'd5, 32'hffffffff, 16'hffff, 16'hffff, 4'd15}, 1'b1,
			'{RES_BAD_PARAM, 6'd0, KIND_NONE, ST_FREE}},
		'{'{REQ_BIND, 6'd5, 32'd0, 16'd0, 16'd1234, 4'd0}, 1'b1,
			'{RES_OK, 6'd5, KIND_NONE, ST_FREE}},
		'{'{REQ_LOOKUP, 6'd0, 32'd0, 16'd0, 16'd1234, 4'd0}, 1'b1,
			'{RES_NOT_FOUND, 6'd0, KIND_NONE, ST_FREE}},
		'{'{REQ_SET, 6'd0, 32'd0, 16'd0, 16'd0, 4'd0}, 1'b1,
			'{RES_OK, 6'd0, KIND_NONE, ST_FREE}}
	};

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			conn_state[i] = ST_FREE;
			conn_lport[i] = '0;
			conn_raddr[i] = '0;
			conn_rport[i] = '0;
		end
		req.valid = 1'b0;
		req.req_type = '0;
		req.slot = '0;
		req.peer_addr = '0;
		req.peer_port = '0;
		req.own_port = '0;
		req.new_conn_state = '0;
		rsp.ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle = 31;
		rx_idle = 46;
		foreach (directed[i])
			send_word(directed[i].word, directed[i].known, directed[i].answer);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				tx_idle = 46;
				rx_idle = 31;
			end
			if (n == 2 * RANDOM_ITEMS / 3) begin
				tx_idle = 0;
				rx_idle = 0;
			end
			// hold off until the table has answered everything
			if (n == RANDOM_ITEMS / 2) begin
				@(negedge clk);
				req.valid <= 1'b0;
				wait (pending_answers.size() == 0);
			end
			send_word(random_word(), 1'b0, '0);
		end
		@(negedge clk);
		req.valid <= 1'b0;

		wait (pending_answers.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
